>>> hdl/kti_pkg.sv
package kti_pkg;

   localparam int DEPTH_DEF          = 16;
   localparam int STEP_FRAC_BITS_DEF = 16;

   localparam logic [1:0] KIND_INSERT = 2'd0;
   localparam logic [1:0] KIND_QUERY  = 2'd1;
   localparam logic [1:0] KIND_CLEAR  = 2'd2;
   localparam logic [1:0] KIND_SPARE  = 2'd3;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_RANGE = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   localparam logic [2:0] ADDR_DEFAULT_VALUE = 3'd0;

   typedef struct packed {
      logic insert_en;
      logic update_en;
      logic valid;
      logic open;
   } cell_ctl_type;

   typedef struct packed {
      logic lt;
      logic le;
      logic eq;
   } cell_flag_type;

endpackage

>>> hdl/kti_cell.sv
module kti_cell #(
   parameter int SW = kti_pkg::STEP_FRAC_BITS_DEF + 1
) (
   input  logic                 clock,
   input  kti_pkg::cell_ctl_type ctl,
   input  logic [SW-1:0]        s,
   input  logic [31:0]          v,
   input  logic                 prev_lt,
   input  logic [SW-1:0]        prev_step,
   input  logic [31:0]          prev_value,
   output kti_pkg::cell_flag_type flags,
   output logic [SW-1:0]        step,
   output logic [31:0]          value
);

   logic [SW-1:0] step_ff, step_in;
   logic [31:0]   value_ff, value_in;

   assign flags.lt = ctl.valid && (step_ff < s);
   assign flags.le = ctl.valid && (step_ff <= s);
   assign flags.eq = ctl.valid && (step_ff == s);

   always_comb begin
      step_in  = step_ff;
      value_in = value_ff;
      if (ctl.update_en && flags.eq) begin
         value_in = v;
      end else if (ctl.insert_en && ctl.open && !flags.lt) begin
         if (prev_lt) begin
            step_in  = s;
            value_in = v;
         end else begin
            step_in  = prev_step;
            value_in = prev_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      step_ff  <= step_in;
      value_ff <= value_in;
   end

   assign step  = step_ff;
   assign value = value_ff;

endmodule

>>> hdl/kti_div.sv
module kti_div #(
   parameter int NW = 51,
   parameter int DW = 17
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic          done,
   output logic [NW-1:0] quot
);

   localparam int CNW = $clog2(NW + 1);

   logic [NW-1:0]  num_ff, num_in, quot_ff, quot_in;
   logic [DW:0]    rem_ff, rem_in, trial;
   logic [DW-1:0]  den_ff, den_in;
   logic [CNW-1:0] cnt_ff, cnt_in;
   logic           busy_ff, busy_in, done_ff, done_in;

   assign trial = {rem_ff[DW-1:0], num_ff[NW-1]};

   always_comb begin
      num_in  = num_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = num;
         den_in  = den;
         rem_in  = '0;
         quot_in = '0;
         cnt_in  = CNW'(NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[NW-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            rem_in  = trial - {1'b0, den_ff};
            quot_in = {quot_ff[NW-2:0], 1'b1};
         end else begin
            rem_in  = trial;
            quot_in = {quot_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

>>> hdl/keyframe_track_interpolator.sv
// channel  direction  payload
// req      in         tuser: kind[1:0]; tdata: step[17:0] value[49:18], zero pad
// rsp      out        tdata: result_value[31:0] status[33:32] entry_count[38:34], zero pad
// csr      in         APB, default_value at byte address 0
// Insert, clear and queries on an empty table or at step one are answered from idle.
// Other queries pass through a multiply state, a divider start state, the bit-serial
// divider that works one quotient bit per cycle, and a final output state.
// Synchronous active-high reset empties the track and zeroes default_value.
// A waiting result holds off the next word until it is taken.
module keyframe_track_interpolator #(
   parameter int DEPTH          = kti_pkg::DEPTH_DEF,
   parameter int STEP_FRAC_BITS = kti_pkg::STEP_FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,  // step, value
   input  logic [1:0]  req_tuser,  // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // result_value, status, entry_count
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int SW  = STEP_FRAC_BITS + 1;
   localparam int CW  = (SW + 1 > 18) ? SW + 1 : 18;
   localparam int CNW = $clog2(DEPTH + 1);
   localparam int NW  = 33 + SW + 1;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_DIVS = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_FIN  = 3'd4;

   logic [SW-1:0] one_s;
   assign one_s = {1'b1, {STEP_FRAC_BITS{1'b0}}};

   logic signed [31:0] default_ff;
   logic [CNW-1:0]     count_ff, count_in;
   logic [2:0]         state_ff, state_in;
   logic               out_valid_ff, out_valid_in;
   logic [31:0]        out_res_ff, out_res_in;
   logic [1:0]         out_status_ff, out_status_in;

   logic signed [32:0] diff_ff;
   logic [SW-1:0]      ds_ff, den_ff;
   logic signed [31:0] vb_ff;
   logic [1:0]         qstat_ff;
   logic signed [NW-1:0] prod_ff;
   logic               neg_ff;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == kti_pkg::ADDR_DEFAULT_VALUE) ? default_ff : 32'd0;
   always_ff @(posedge clock) begin
      if (reset) begin
         default_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite &&
                   csr_paddr == kti_pkg::ADDR_DEFAULT_VALUE) begin
         default_ff <= csr_pwdata;
      end
   end

   // input decode
   logic [1:0]          kind;
   logic signed [17:0]  step_in;
   logic signed [31:0]  val_in;
   logic signed [CW-1:0] step_x, one_x;
   logic                neg, over;
   logic [SW-1:0]       s_cmp;
   logic                fire;

   assign kind    = req_tuser[1:0];
   assign step_in = req_tdata[17:0];
   assign val_in  = req_tdata[49:18];
   assign step_x  = CW'(step_in);
   assign one_x   = {{(CW - SW){1'b0}}, one_s};
   assign neg     = step_in[17];
   assign over    = step_x > one_x;
   assign s_cmp   = neg ? '0 : (over ? one_s : step_x[SW-1:0]);
   assign fire    = req_tvalid && req_tready;

   // cell row
   kti_pkg::cell_ctl_type  ctl   [DEPTH];
   kti_pkg::cell_flag_type flags [DEPTH];
   logic [SW-1:0] steps  [DEPTH];
   logic [31:0]   values [DEPTH];
   logic          any_eq, full, ins_ok;

   always_comb begin
      any_eq = 1'b0;
      for (int i = 0; i < DEPTH; i++) any_eq = any_eq | flags[i].eq;
   end
   assign full   = count_ff == CNW'(DEPTH);
   assign ins_ok = fire && kind == kti_pkg::KIND_INSERT && !neg && !over;

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      assign ctl[g].insert_en = ins_ok && !any_eq && !full;
      assign ctl[g].update_en = ins_ok;
      assign ctl[g].valid     = CNW'(g) < count_ff;
      assign ctl[g].open      = CNW'(g) <= count_ff;
      if (g == 0) begin : g_first
         kti_cell #(.SW(SW)) u_cell (
            .clock(clock), .ctl(ctl[g]), .s(s_cmp), .v(val_in),
            .prev_lt(1'b1), .prev_step('0), .prev_value('0),
            .flags(flags[g]), .step(steps[g]), .value(values[g]));
      end else begin : g_rest
         kti_cell #(.SW(SW)) u_cell (
            .clock(clock), .ctl(ctl[g]), .s(s_cmp), .v(val_in),
            .prev_lt(flags[g-1].lt), .prev_step(steps[g-1]), .prev_value(values[g-1]),
            .flags(flags[g]), .step(steps[g]), .value(values[g]));
      end
   end

   // bracket selection
   logic          any_le, any_gt;
   logic [SW-1:0] sb_sel, sa_sel, sb, sa;
   logic [31:0]   vb_sel, va_sel, last_v;
   logic signed [31:0] vb, va;
   logic          below_i, above_i, nxt_le, prv_le;

   always_comb begin
      any_le = 1'b0; any_gt = 1'b0;
      sb_sel = '0; sa_sel = '0; vb_sel = '0; va_sel = '0; last_v = '0;
      for (int i = 0; i < DEPTH; i++) begin
         nxt_le  = (i == DEPTH - 1) ? 1'b0 : flags[(i + 1) % DEPTH].le;
         prv_le  = (i == 0) ? 1'b1 : flags[(i + DEPTH - 1) % DEPTH].le;
         below_i = flags[i].le && !nxt_le;
         above_i = ctl[i].valid && !flags[i].le && prv_le;
         any_le  = any_le | flags[i].le;
         any_gt  = any_gt | above_i;
         sb_sel  = sb_sel | (below_i ? steps[i] : '0);
         vb_sel  = vb_sel | (below_i ? values[i] : '0);
         sa_sel  = sa_sel | (above_i ? steps[i] : '0);
         va_sel  = va_sel | (above_i ? values[i] : '0);
         last_v  = last_v | ((CNW'(i + 1) == count_ff) ? values[i] : '0);
      end
   end
   assign sb = any_le ? sb_sel : '0;
   assign vb = any_le ? vb_sel : default_ff;
   assign sa = any_gt ? sa_sel : one_s;
   assign va = any_gt ? va_sel : last_v;

   // magnitude and sign of the product, ready for the divider start
   logic [NW-1:0] prod_mag;
   logic [NW-1:0] mag_live;
   logic          neg_live;
   assign prod_mag = prod_ff[NW-1] ? NW'(-prod_ff) : NW'(prod_ff);
   assign mag_live = prod_mag;
   assign neg_live = prod_ff[NW-1];

   // divider
   logic          div_start, div_done;
   logic [NW-1:0] quot;
   kti_div #(.NW(NW), .DW(SW)) u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .num(mag_live), .den(den_ff), .done(div_done), .quot(quot));
   assign div_start = state_ff == ST_DIVS;

   logic signed [NW+1:0] q_s, sum;
   logic signed [31:0]   sat;
   assign q_s  = neg_ff ? -$signed({2'b00, quot}) : $signed({2'b00, quot});
   assign sum  = (NW+2)'(vb_ff) + q_s;
   assign sat  = (sum > (NW+2)'(32'sh7fffffff)) ? 32'sh7fffffff :
                 (sum < -(NW+2)'(33'sh080000000)) ? 32'sh80000000 : sum[31:0];

   logic out_free;
   assign out_free   = !out_valid_ff || rsp_tready;
   assign req_tready = state_ff == ST_IDLE && out_free;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_res_in    = out_res_ff;
      out_status_in = out_status_ff;
      case (state_ff)
         ST_IDLE: begin
            if (fire) begin
               out_res_in    = '0;
               out_status_in = kti_pkg::STATUS_OK;
               case (kind)
                  kti_pkg::KIND_INSERT: begin
                     out_valid_in = 1'b1;
                     if (neg || over) begin
                        out_status_in = kti_pkg::STATUS_RANGE;
                     end else if (!any_eq && full) begin
                        out_status_in = kti_pkg::STATUS_FULL;
                     end else if (!any_eq) begin
                        count_in = count_ff + 1'b1;
                     end
                  end
                  kti_pkg::KIND_QUERY: begin
                     out_status_in = (neg || over) ? kti_pkg::STATUS_RANGE
                                                   : kti_pkg::STATUS_OK;
                     if (count_ff == '0) begin
                        out_res_in   = default_ff;
                        out_valid_in = 1'b1;
                     end else if (s_cmp == one_s) begin
                        out_res_in   = last_v;
                        out_valid_in = 1'b1;
                     end else begin
                        state_in = ST_MUL;
                     end
                  end
                  kti_pkg::KIND_CLEAR: begin
                     count_in     = '0;
                     out_valid_in = 1'b1;
                  end
                  default: out_valid_in = 1'b1;
               endcase
            end
         end
         ST_MUL:  state_in = ST_DIVS;
         ST_DIVS: state_in = ST_DIV;
         ST_DIV:  if (div_done) state_in = ST_FIN;
         ST_FIN: begin
            if (out_free) begin
               out_res_in    = sat;
               out_status_in = qstat_ff;
               out_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         diff_ff  <= 33'(va) - 33'(vb);
         ds_ff    <= s_cmp - sb;
         den_ff   <= sa - sb;
         vb_ff    <= vb;
         qstat_ff <= (neg || over) ? kti_pkg::STATUS_RANGE : kti_pkg::STATUS_OK;
      end
      if (state_ff == ST_MUL) begin
         prod_ff <= NW'(diff_ff * $signed({1'b0, ds_ff}));
      end
      if (state_ff == ST_DIVS) begin
         neg_ff <= neg_live;
      end
      out_res_ff    <= out_res_in;
      out_status_ff <= out_status_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, 5'(count_ff), out_status_ff, out_res_ff};

endmodule
